>>> sv/lpqs_pkg.sv
// Shared types and constants for the quarter-scan LED panel frame store.
// No dependencies; every other file imports this package.
package lpqs_pkg;

   localparam int CHANNEL_COUNT          = 8;
   localparam int COLOR_W                = 3;
   localparam int MODULES_ACROSS_DEFAULT = 7;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } seq_state_type;

   // Memory command from the sequencer to the channel memories
   typedef struct packed {
      logic [CHANNEL_COUNT-1:0] wr_sel;
      logic                     rd_en;
   } mem_ctl_type;

   // Sequencer status towards the read stage
   typedef struct packed {
      logic       clearing;
      logic       tick_acc;
      logic       tick_last;
      logic [1:0] tick_row;
   } seq_status_type;

endpackage

>>> sv/lpqs_if.sv
// Valid/ready channel interfaces for pixel writes/shift ticks and shift results.
// Depends on lpqs_pkg for the colour and channel widths.
interface lpqs_req_if import lpqs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         x;
   logic [5:0]         y;
   logic [COLOR_W-1:0] color;
   logic [1:0]         scan_line;

   modport source (output valid, kind, x, y, color, scan_line, input ready);
   modport sink   (input valid, kind, x, y, color, scan_line, output ready);
endinterface

interface lpqs_rsp_if import lpqs_pkg::*; ();
   logic                               valid;
   logic                               ready;
   logic [CHANNEL_COUNT*COLOR_W-1:0]   channel_bits;
   logic [1:0]                         row_address;
   logic                               last_in_line;

   modport source (output valid, channel_bits, row_address, last_in_line, input ready);
   modport sink   (input valid, channel_bits, row_address, last_in_line, output ready);
endinterface

>>> sv/led_panel_quarter_scan_remap.sv
// Top level of the quarter-scan LED panel frame store and shift sequencer.
// Depends on lpqs_pkg, lpqs_if, lpqs_chan_mem and lpqs_sequencer.
//
// req carries one transaction per pixel write (kind 0: x, y, color) or per
// shift tick (kind 1: scan_line). A write lands in the frame store at the
// accepting edge and gives no response. A tick reads the current column of
// the given scan line from all eight channel memories at once and yields one
// rsp transaction: 24 colour bits, the row address and a last-in-line flag.
// The column counter wraps after 64*MODULES_ACROSS ticks.
// A tick response passes the memory read register, then the output register,
// before rsp presents it. One transaction per cycle is taken while rsp keeps
// up; the single memory read port per channel sets it.
// When rsp stalls, one response sits in the output register and one in the
// read register; req.ready then drops until the output register drains.
// Reset starts a clearing pass that zeroes all 4*2**clog2(64*MODULES_ACROSS)
// entries of the store (2048 at the default of 7); req.ready stays low
// throughout, and the column counter restarts at zero.
module led_panel_quarter_scan_remap import lpqs_pkg::*; #(
   parameter int MODULES_ACROSS = MODULES_ACROSS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lpqs_req_if.sink  req,
   lpqs_rsp_if.source rsp
);

   localparam int COL_W  = $clog2(64 * MODULES_ACROSS);
   localparam int ADDR_W = COL_W + 2;
   localparam int BITS_W = CHANNEL_COUNT * COLOR_W;

   mem_ctl_type       mem_ctl;
   seq_status_type    status;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [COLOR_W-1:0] wr_data;
   logic [BITS_W-1:0] rd_bits;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_row_ff;
   logic              s1_last_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BITS_W-1:0] out_bits_ff;
   logic [1:0]        out_row_ff;
   logic              out_last_ff;
   logic              s1_adv;
   logic              can_take;

   lpqs_sequencer #(
      .MODULES_ACROSS (MODULES_ACROSS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .can_take (can_take),
      .mem_ctl  (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .status   (status)
   );

   for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_chan
      lpqs_chan_mem #(
         .ADDR_W (ADDR_W)
      ) u_mem (
         .clock   (clock),
         .wr_en   (mem_ctl.wr_sel[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (mem_ctl.rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_bits[COLOR_W*g +: COLOR_W])
      );
   end

   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign can_take = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (status.tick_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.tick_acc) begin
         s1_row_ff  <= status.tick_row;
         s1_last_ff <= status.tick_last;
      end
      if (s1_adv) begin
         out_bits_ff <= rd_bits;
         out_row_ff  <= s1_row_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.channel_bits = out_bits_ff;
   assign rsp.row_address  = out_row_ff;
   assign rsp.last_in_line = out_last_ff;

   // no transaction is taken while the store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req.ready)
      else $error("req ready during clearing pass");

   // a new read must never overwrite an undelivered one in the read register
   assert property (@(posedge clock) disable iff (reset)
      status.tick_acc |-> (!s1_valid_ff || s1_adv))
      else $error("read register overrun");

   // outside the clearing pass, the store is written only by an accepted pixel write
   assert property (@(posedge clock) disable iff (reset)
      (!status.clearing && (mem_ctl.wr_sel != '0))
         |-> (req.valid && req.ready && !req.kind))
      else $error("spurious frame store write");

   // the read register only becomes busy through an accepted tick
   assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !status.tick_acc) |=> !s1_valid_ff)
      else $error("read register valid without a tick");

endmodule

>>> sv/lpqs_chan_mem.sv
// Frame store of one colour channel: 3-bit entries, one write and one read port,
// read data registered. Depends on lpqs_pkg.
module lpqs_chan_mem import lpqs_pkg::*; #(
   parameter int ADDR_W = 11
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [COLOR_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [COLOR_W-1:0] rd_data
);

   logic [COLOR_W-1:0] mem [2**ADDR_W];
   logic [COLOR_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

>>> sv/lpqs_sequencer.sv
// Clearing sweep, pixel address remap and shift column counter.
// Drives the channel memories; depends on lpqs_pkg and lpqs_if.
module lpqs_sequencer import lpqs_pkg::*; #(
   parameter int MODULES_ACROSS = MODULES_ACROSS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   lpqs_req_if.sink              req,
   input  logic                  can_take,
   output mem_ctl_type           mem_ctl,
   output logic [$clog2(64*MODULES_ACROSS)+1:0] wr_addr,
   output logic [COLOR_W-1:0]    wr_data,
   output logic [$clog2(64*MODULES_ACROSS)+1:0] rd_addr,
   output seq_status_type        status
);

   localparam int LinePixels = 64 * MODULES_ACROSS;
   localparam int PanelWidth = 32 * MODULES_ACROSS;
   localparam int COL_W      = $clog2(LinePixels);
   localparam int ADDR_W     = COL_W + 2;

   seq_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [COL_W-1:0]  pos_ff, pos_in;
   logic [COL_W-1:0]  pos;
   logic [COL_W-1:0]  wr_col;
   logic              accept;
   logic              last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pos_ff   <= pos_in;
      end
   end

   // column within a line: group x/8 at stride 16, lower half-row adds 8
   assign wr_col = COL_W'({req.x[7:3], req.y[2], req.x[2:0]});
   assign pos    = (int'(pos_ff) >= LinePixels) ? '0 : pos_ff;
   assign last   = (pos == COL_W'(LinePixels - 1));

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      pos_in         = pos_ff;
      req.ready      = 1'b0;
      accept         = 1'b0;
      mem_ctl.wr_sel = '0;
      mem_ctl.rd_en  = 1'b0;
      wr_addr        = {req.y[1:0], wr_col};
      wr_data        = req.color;
      rd_addr        = {req.scan_line, pos};
      status.clearing  = 1'b0;
      status.tick_acc  = 1'b0;
      status.tick_last = last;
      status.tick_row  = req.scan_line;
      case (state_ff)
         ST_CLEAR: begin
            status.clearing = 1'b1;
            mem_ctl.wr_sel  = '1;
            wr_addr         = clr_ff;
            wr_data         = '0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req.ready = can_take;
            accept    = req.valid && can_take;
            if (accept && !req.kind) begin
               if (int'(req.x) < PanelWidth) begin
                  mem_ctl.wr_sel = CHANNEL_COUNT'(1) << req.y[5:3];
               end
            end
            if (accept && req.kind) begin
               mem_ctl.rd_en   = 1'b1;
               status.tick_acc = 1'b1;
               pos_in          = last ? '0 : pos + 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

>>> test/lpqs_tb_pkg.sv
// Testbench-side types for the quarter-scan panel: request kinds and the shape
// of one shifted column. Depends on lpqs_pkg for channel count and colour width.
package lpqs_tb_pkg;
   import lpqs_pkg::*;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_TICK  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [CHANNEL_COUNT*COLOR_W-1:0] channel_bits;
      logic [1:0]                       row_address;
      logic                             last_in_line;
   } shift_column_type;

endpackage

>>> test/lpqs_column_checker.sv
// Passive checker: mirrors the remapped frame store and column counter, predicts
// every shifted column and compares it with rsp. Depends on lpqs_pkg, lpqs_tb_pkg, lpqs_if.
module lpqs_column_checker import lpqs_pkg::*; import lpqs_tb_pkg::*; #(
   parameter int MODULES_ACROSS = MODULES_ACROSS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   lpqs_req_if  req,
   lpqs_rsp_if  rsp,
   output int   error_count,
   output int   columns_due
);
   localparam int PANEL_WIDTH    = 32 * MODULES_ACROSS;
   localparam int LINE_PIXELS    = 64 * MODULES_ACROSS;
   localparam int CHAN_STRIDE    = 256 * MODULES_ACROSS;
   localparam int STORE_DEPTH    = CHANNEL_COUNT * CHAN_STRIDE;

   logic [COLOR_W-1:0] panel_image [STORE_DEPTH];
   int                 scan_column;
   shift_column_type   column_q [$];

   function automatic int remap_address(input logic [7:0] px, input logic [5:0] py);
      return (int'(py) / 8) * CHAN_STRIDE + (int'(py) % 4) * LINE_PIXELS
           + ((int'(py) % 8) / 4) * 8 + (int'(px) / 8) * 16 + int'(px) % 8;
   endfunction

   function automatic shift_column_type read_column(input logic [1:0] line);
      shift_column_type col;
      col.channel_bits = '0;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++)
         col.channel_bits[ch*COLOR_W +: COLOR_W] =
            panel_image[ch*CHAN_STRIDE + int'(line)*LINE_PIXELS + scan_column];
      col.row_address  = line;
      col.last_in_line = (scan_column == LINE_PIXELS - 1);
      return col;
   endfunction

   always @(posedge clock) begin : watch
      shift_column_type want, got;
      int               errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++)
            panel_image[i] = '0;
         scan_column = 0;
         column_q.delete();
         error_count <= 0;
      end else begin
         if (req.valid && req.ready) begin
            if (req.kind == KIND_TICK) begin
               column_q.push_back(read_column(req.scan_line));
               scan_column = (scan_column == LINE_PIXELS - 1) ? 0 : scan_column + 1;
            end else if (int'(req.x) < PANEL_WIDTH) begin
               panel_image[remap_address(req.x, req.y)] = req.color;
            end
         end
         if (rsp.valid && rsp.ready) begin
            got.channel_bits = rsp.channel_bits;
            got.row_address  = rsp.row_address;
            got.last_in_line = rsp.last_in_line;
            if (column_q.size() == 0) begin
               $display("%0t: column with none due: bits %h row %0d last %0b",
                        $time, got.channel_bits, got.row_address, got.last_in_line);
               errs++;
            end else begin
               want = column_q.pop_front();
               if (got.channel_bits !== want.channel_bits) begin
                  $display("%0t: channel_bits expected %h actual %h",
                           $time, want.channel_bits, got.channel_bits);
                  errs++;
               end
               if (got.row_address !== want.row_address) begin
                  $display("%0t: row_address expected %0d actual %0d",
                           $time, want.row_address, got.row_address);
                  errs++;
               end
               if (got.last_in_line !== want.last_in_line) begin
                  $display("%0t: last_in_line expected %0b actual %0b",
                           $time, want.last_in_line, got.last_in_line);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
      columns_due <= column_q.size();
   end

endmodule

>>> test/tb_top.sv
// Top of the quarter-scan panel testbench: clock, reset, pixel/tick stimulus and
// rsp back-pressure, verdict. Depends on lpqs_pkg, lpqs_tb_pkg, lpqs_if and the checker.
module tb_top import lpqs_pkg::*; import lpqs_tb_pkg::*; ;
   localparam int LINE_PIXELS = 64 * MODULES_ACROSS_DEFAULT;
   localparam int DRAIN_LIMIT = 20000;

   logic clock;
   logic reset;
   int   error_count;
   int   columns_due;
   int   holdoff_asks = 0;
   int   holdoff_done = 0;
   int   burst_left   = 0;
   int   items_sent   = 0;
   int   ticks_sent   = 0;
   int   next_column  = 0;

   lpqs_req_if req();
   lpqs_rsp_if rsp();

   led_panel_quarter_scan_remap u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   lpqs_column_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .error_count (error_count),
      .columns_due (columns_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_item(input req_kind_type kind, input logic [7:0] px,
                            input logic [5:0] py, input logic [2:0] colour,
                            input logic [1:0] line);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid     <= 1'b1;
      req.kind      <= kind;
      req.x         <= px;
      req.y         <= py;
      req.color     <= colour;
      req.scan_line <= line;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      if (kind == KIND_TICK) begin
         ticks_sent++;
         next_column = (next_column + 1) % LINE_PIXELS;
      end
   endtask

   // Write one pixel so that it lands at (channel, scan line, column) of the store.
   task automatic put_pixel(input int ch, input int line, input int col,
                            input logic [2:0] colour);
      int px, py;
      px = (col / 16) * 8 + col % 8;
      py = ch * 8 + ((col % 16) / 8) * 4 + line;
      send_item(KIND_WRITE, 8'(px), 6'(py), colour, 2'($urandom_range(0, 3)));
   endtask

   task automatic shift_tick(input logic [1:0] line);
      send_item(KIND_TICK, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                3'($urandom_range(0, 7)), line);
   endtask

   task automatic noise_write();
      send_item(KIND_WRITE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
   endtask

   task automatic pause_until_drained();
      req.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (columns_due != 0);
   endtask

   // Response side: stall patterns of its own plus requested long hold-offs.
   initial begin : rsp_side
      int mode, left, hold;
      mode = 0;
      left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_asks != holdoff_done) begin
            hold = $urandom_range(60, 100);
            rsp.ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
            holdoff_done++;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(16, 80);
            end
            left--;
            case (mode)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= 1'($urandom_range(0, 1));
               2: rsp.ready <= ($urandom_range(0, 3) != 0);
               default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int seg, n, line, waited;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.kind      <= KIND_WRITE;
      req.x         <= '0;
      req.y         <= '0;
      req.color     <= '0;
      req.scan_line <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: every channel of column 0, a few early columns, corner pixels,
      // off-screen columns, then ticks that change line mid-line.
      for (int ch = 0; ch < CHANNEL_COUNT; ch++)
         put_pixel(ch, 0, 0, 3'(ch));
      put_pixel(7, 1, 1, 3'd7);
      put_pixel(0, 2, 2, 3'd5);
      put_pixel(7, 2, 2, 3'd2);
      put_pixel(0, 3, 3, 3'd7);
      send_item(KIND_WRITE, 8'd223, 6'd63, 3'd7, 2'd0);
      send_item(KIND_WRITE, 8'd224, 6'd63, 3'd5, 2'd3);
      send_item(KIND_WRITE, 8'd255, 6'd0, 3'd3, 2'd1);
      send_item(KIND_WRITE, 8'd255, 6'd63, 3'd7, 2'd2);
      send_item(KIND_TICK, 8'd255, 6'd63, 3'd7, 2'd0);
      send_item(KIND_TICK, 8'd0, 6'd0, 3'd0, 2'd1);
      shift_tick(2'd2);
      shift_tick(2'd3);
      pause_until_drained();

      // Long rsp hold-off while ticks keep coming, so req backs up.
      holdoff_asks++;
      repeat (40) shift_tick(2'($urandom_range(0, 3)));
      pause_until_drained();

      while (items_sent < 950 || ticks_sent < LINE_PIXELS + 32) begin
         seg = $urandom_range(0, 9);
         if (seg <= 4) begin
            // fill the columns about to be shifted, then shift them
            line = $urandom_range(0, 3);
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               repeat ($urandom_range(1, 3))
                  put_pixel($urandom_range(0, 7), line, (next_column + i) % LINE_PIXELS,
                            3'($urandom_range(0, 7)));
               if ($urandom_range(0, 3) == 0)
                  noise_write();
            end
            for (int i = 0; i < n; i++)
               shift_tick(($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                                      : 2'(line));
         end else if (seg <= 7) begin
            line = $urandom_range(0, 3);
            repeat ($urandom_range(4, 32))
               shift_tick(($urandom_range(0, 1) == 0) ? 2'(line)
                                                      : 2'($urandom_range(0, 3)));
         end else if (seg == 8) begin
            repeat ($urandom_range(1, 6)) noise_write();
         end else if ($urandom_range(0, 1) == 0) begin
            pause_until_drained();
         end else begin
            holdoff_asks++;
            repeat (24) shift_tick(2'($urandom_range(0, 3)));
         end
      end

      req.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (columns_due != 0 && waited < DRAIN_LIMIT);

      if (columns_due != 0) begin
         $display("%0t: timed out with %0d shift columns outstanding", $time, columns_due);
         $display("tb_top: errors");
         $finish;
      end else begin
         repeat (6) @(posedge clock);
         if (error_count == 0 && columns_due == 0)
            $display("tb_top: clean");
         else
            $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      #5000000;
      $display("%0t: run limit reached", $time);
      $display("tb_top: errors");
      $finish;
   end

endmodule
